/* hw/rtl/ptse_pkg.sv */
// ----------------------------------------------------------------------------
// ptse_pkg: shared types and constants of the polygon translate/scale engine
// Payload structs for both channels, command encoding between the front and
// the back half, key codes and the fixed-point constants.
// ----------------------------------------------------------------------------
package ptse_pkg;

  localparam int COORD_W   = 24;  // signed Q15.8 coordinate
  localparam int VIDX_W    = 5;   // vertex index field
  localparam int KEY_W     = 8;
  localparam int CFG_W     = 6;   // vertex_count register
  localparam int FACTOR_W  = 17;  // unsigned Q1.16 scale factor
  localparam int RND_SHIFT = 16;
  localparam int EXT_W     = COORD_W + 4;  // headroom before saturation
  localparam int OP_W      = 3;

  localparam logic [CFG_W-1:0] VCOUNT_RESET = CFG_W'(3);

  localparam logic signed [COORD_W-1:0] STEP_Q8 = COORD_W'(2560);
  localparam logic [FACTOR_W-1:0] SCALE_UP_Q16   = FACTOR_W'(68813);
  localparam logic [FACTOR_W-1:0] SCALE_DOWN_Q16 = FACTOR_W'(62259);
  localparam logic [EXT_W-1:0] RND_HALF = EXT_W'(32768);

  localparam logic signed [EXT_W-1:0] COORD_MAX_EXT = EXT_W'((1 << (COORD_W - 1)) - 1);
  localparam logic signed [EXT_W-1:0] COORD_MIN_EXT = -COORD_MAX_EXT - EXT_W'(1);

  // request types
  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_KEY  = 1'b1;

  // ASCII
  localparam logic [KEY_W-1:0] ASCII_UC_A = 8'h41;
  localparam logic [KEY_W-1:0] ASCII_UC_Z = 8'h5A;
  localparam logic [KEY_W-1:0] CASE_OFS   = 8'h20;
  localparam logic [KEY_W-1:0] KEY_UP     = 8'h77;  // w
  localparam logic [KEY_W-1:0] KEY_LEFT   = 8'h61;  // a
  localparam logic [KEY_W-1:0] KEY_DOWN   = 8'h73;  // s
  localparam logic [KEY_W-1:0] KEY_RIGHT  = 8'h64;  // d
  localparam logic [KEY_W-1:0] KEY_GROW   = 8'h69;  // i
  localparam logic [KEY_W-1:0] KEY_SHRINK = 8'h6F;  // o

  // command opcodes
  localparam logic [OP_W-1:0] OP_LOAD   = 3'd0;
  localparam logic [OP_W-1:0] OP_UP     = 3'd1;
  localparam logic [OP_W-1:0] OP_LEFT   = 3'd2;
  localparam logic [OP_W-1:0] OP_DOWN   = 3'd3;
  localparam logic [OP_W-1:0] OP_RIGHT  = 3'd4;
  localparam logic [OP_W-1:0] OP_GROW   = 3'd5;
  localparam logic [OP_W-1:0] OP_SHRINK = 3'd6;

  typedef struct packed {
    logic                      req_type;
    logic [VIDX_W-1:0]         vertex_index;
    logic signed [COORD_W-1:0] coord_x;
    logic signed [COORD_W-1:0] coord_y;
    logic [KEY_W-1:0]          key_code;
  } in_item_t;

  typedef struct packed {
    logic [VIDX_W-1:0]         out_index;
    logic signed [COORD_W-1:0] out_x;
    logic signed [COORD_W-1:0] out_y;
    logic                      last_vertex;
  } out_item_t;

  typedef struct packed {
    logic [OP_W-1:0]           op;
    logic [VIDX_W-1:0]         idx;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
  } cmd_t;

  function automatic logic signed [COORD_W-1:0] sat_coord(
      input logic signed [EXT_W-1:0] v);
    logic signed [COORD_W-1:0] res;
    if (v > COORD_MAX_EXT) begin
      res = COORD_MAX_EXT[COORD_W-1:0];
    end else if (v < COORD_MIN_EXT) begin
      res = COORD_MIN_EXT[COORD_W-1:0];
    end else begin
      res = v[COORD_W-1:0];
    end
    return res;
  endfunction

endpackage

/* hw/rtl/ptse_ram.sv */
// ----------------------------------------------------------------------------
// ptse_ram: generic single-write, single-read RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module ptse_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule

/* hw/rtl/ptse_div.sv */
// ----------------------------------------------------------------------------
// ptse_div: iterative signed-by-unsigned divider
// Restoring division, one quotient bit per cycle, truncates toward zero.
// ----------------------------------------------------------------------------
module ptse_div #(
  parameter int DIVIDEND_W = 30,
  parameter int DIVISOR_W  = 6
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic signed [DIVIDEND_W-1:0] dividend,
  input  logic [DIVISOR_W-1:0]         divisor,
  output logic                         busy,
  output logic signed [DIVIDEND_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DIVIDEND_W + 1);

  logic                  busy_r, busy_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic                  neg_r;
  logic [DIVIDEND_W-1:0] quo_r;
  logic [DIVISOR_W-1:0]  rem_r;
  logic [DIVISOR_W:0]    trial;
  logic                  take;

  assign trial = {rem_r, quo_r[DIVIDEND_W-1]};
  assign take  = (trial >= {1'b0, divisor});

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(DIVIDEND_W);
    end else if (busy_r) begin
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    if (start) begin
      neg_r <= dividend[DIVIDEND_W-1];
      quo_r <= dividend[DIVIDEND_W-1] ? -dividend : dividend;
      rem_r <= '0;
    end else if (busy_r) begin
      quo_r <= {quo_r[DIVIDEND_W-2:0], take};
      rem_r <= take ? DIVISOR_W'(trial - {1'b0, divisor}) : trial[DIVISOR_W-1:0];
    end
  end

  assign busy     = busy_r;
  assign quotient = neg_r ? -$signed(quo_r) : $signed(quo_r);

endmodule

/* hw/rtl/ptse_front.sv */
// ----------------------------------------------------------------------------
// ptse_front: input decode
// Takes input transactions, folds key case, turns them into commands and
// drops unknown keys and out-of-range loads.
// ----------------------------------------------------------------------------
module ptse_front import ptse_pkg::*; #(
  parameter int MAX_VERTICES = 32
) (
  input  logic     in_valid,
  output logic     in_stall,
  input  in_item_t in_data,
  input  logic     q_full,
  output logic     q_push,
  output cmd_t     q_cmd
);

  logic [KEY_W-1:0] key_lc;
  logic             keep;

  always_comb begin
    key_lc = in_data.key_code;
    if (in_data.key_code inside {[ASCII_UC_A:ASCII_UC_Z]}) begin
      key_lc = in_data.key_code + CASE_OFS;
    end

    q_cmd.idx = in_data.vertex_index;
    q_cmd.x   = in_data.coord_x;
    q_cmd.y   = in_data.coord_y;
    q_cmd.op  = OP_LOAD;
    keep      = 1'b1;

    if (in_data.req_type == REQ_LOAD) begin
      keep = (32'(in_data.vertex_index) < MAX_VERTICES);
    end else begin
      case (key_lc)
        KEY_UP:     q_cmd.op = OP_UP;
        KEY_LEFT:   q_cmd.op = OP_LEFT;
        KEY_DOWN:   q_cmd.op = OP_DOWN;
        KEY_RIGHT:  q_cmd.op = OP_RIGHT;
        KEY_GROW:   q_cmd.op = OP_GROW;
        KEY_SHRINK: q_cmd.op = OP_SHRINK;
        default:    keep = 1'b0;
      endcase
    end
  end

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full && keep;

endmodule

/* hw/rtl/ptse_cmd_q.sv */
// ----------------------------------------------------------------------------
// ptse_cmd_q: two-entry command queue
// Decouples input decode from the vertex engine.
// ----------------------------------------------------------------------------
module ptse_cmd_q import ptse_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic empty,
  output cmd_t head
);

  localparam int DEPTH = 2;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  cmd_t             buf_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + PTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + PTR_W'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
    if (push) begin
      buf_r[wr_ptr_r] <= push_cmd;
    end
  end

  assign full  = (cnt_r == CNT_W'(DEPTH));
  assign empty = (cnt_r == '0);
  assign head  = buf_r[rd_ptr_r];

endmodule

/* hw/rtl/ptse_back.sv */
// ----------------------------------------------------------------------------
// ptse_back: vertex engine
// Owns the vertex RAM, executes loads, translations and scaling about the
// centroid, and drives the result register.
// ----------------------------------------------------------------------------
module ptse_back import ptse_pkg::*; #(
  parameter int MAX_VERTICES = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_empty,
  input  cmd_t             q_head,
  output logic             q_pop,
  input  logic [CFG_W-1:0] vertex_count,
  output logic             out_valid,
  input  logic             out_stall,
  output out_item_t        out_data
);

  localparam int IDX_W = $clog2(MAX_VERTICES);
  localparam int CNT_W = $clog2(MAX_VERTICES + 1);
  localparam int SUM_W = COORD_W + CNT_W;
  localparam int RAM_W = 2 * COORD_W;
  localparam int P_W   = COORD_W + FACTOR_W + 2;
  localparam int Q_W   = P_W - RND_SHIFT;

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_SUM     = 3'd1;
  localparam logic [2:0] S_DIV_GO  = 3'd2;
  localparam logic [2:0] S_DIV_WT  = 3'd3;
  localparam logic [2:0] S_UPD_RD  = 3'd4;
  localparam logic [2:0] S_UPD_MUL = 3'd5;
  localparam logic [2:0] S_UPD_RND = 3'd6;
  localparam logic [2:0] S_UPD_WR  = 3'd7;

  logic [2:0]       state_r, state_nxt;
  logic [CNT_W-1:0] i_r, n_r, n_act;
  logic             rd_vld_r;
  logic             scale_r;
  logic [FACTOR_W-1:0] factor_r;
  logic signed [COORD_W-1:0] dx_r, dy_r, cx_r, cy_r, vx_r, vy_r;
  logic signed [SUM_W-1:0]   sx_r, sy_r, qx_div, qy_div;
  logic signed [P_W-1:0]     px_r, py_r;
  logic [Q_W-1:0]            qx_r, qy_r;
  logic                      negx_r, negy_r;
  logic                      out_valid_r;
  out_item_t                 out_data_r;

  logic             ram_we, ram_re, div_start, busy_x, busy_y, last, wr_fire;
  logic [IDX_W-1:0] ram_waddr, ram_raddr;
  logic [RAM_W-1:0] ram_wdata, ram_rdata;
  logic signed [COORD_W-1:0] rd_x, rd_y, new_x, new_y;
  logic signed [P_W-1:0]     mag_x, mag_y;
  logic signed [EXT_W-1:0]   rx, ry, tx, ty;
  logic                      is_scale_op;

  assign rd_x = ram_rdata[RAM_W-1:COORD_W];
  assign rd_y = ram_rdata[COORD_W-1:0];

  // active vertex count: zero means one, clamp to the table depth
  always_comb begin
    if (vertex_count == '0) begin
      n_act = CNT_W'(1);
    end else if (32'(vertex_count) > MAX_VERTICES) begin
      n_act = CNT_W'(MAX_VERTICES);
    end else begin
      n_act = CNT_W'(vertex_count);
    end
  end

  assign is_scale_op = (q_head.op == OP_GROW) || (q_head.op == OP_SHRINK);
  assign last        = (i_r == n_r - CNT_W'(1));
  assign wr_fire     = (state_r == S_UPD_WR) && (!out_valid_r || !out_stall);

  always_comb begin
    state_nxt = state_r;
    q_pop     = 1'b0;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    div_start = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (!q_empty) begin
          q_pop = 1'b1;
          if (q_head.op == OP_LOAD) begin
            ram_we = 1'b1;
          end else if (is_scale_op) begin
            state_nxt = S_SUM;
          end else begin
            state_nxt = S_UPD_RD;
          end
        end
      end
      S_SUM: begin
        ram_re = (i_r != n_r);
        if (i_r == n_r && !rd_vld_r) begin
          state_nxt = S_DIV_GO;
        end
      end
      S_DIV_GO: begin
        div_start = 1'b1;
        state_nxt = S_DIV_WT;
      end
      S_DIV_WT: begin
        if (!busy_x && !busy_y) begin
          state_nxt = S_UPD_RD;
        end
      end
      S_UPD_RD: begin
        ram_re    = 1'b1;
        state_nxt = S_UPD_MUL;
      end
      S_UPD_MUL: state_nxt = S_UPD_RND;
      S_UPD_RND: state_nxt = S_UPD_WR;
      S_UPD_WR: begin
        if (wr_fire) begin
          ram_we    = 1'b1;
          state_nxt = last ? S_IDLE : S_UPD_RD;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // rounded offset from the centroid, ties away from zero
  assign mag_x = px_r[P_W-1] ? -px_r : px_r;
  assign mag_y = py_r[P_W-1] ? -py_r : py_r;

  assign rx = negx_r ? -EXT_W'($signed({1'b0, qx_r})) : EXT_W'($signed({1'b0, qx_r}));
  assign ry = negy_r ? -EXT_W'($signed({1'b0, qy_r})) : EXT_W'($signed({1'b0, qy_r}));

  always_comb begin
    if (scale_r) begin
      tx = EXT_W'(cx_r) + rx;
      ty = EXT_W'(cy_r) + ry;
    end else begin
      tx = EXT_W'(vx_r) + EXT_W'(dx_r);
      ty = EXT_W'(vy_r) + EXT_W'(dy_r);
    end
    new_x = sat_coord(tx);
    new_y = sat_coord(ty);
  end

  assign ram_raddr = i_r[IDX_W-1:0];
  assign ram_waddr = (state_r == S_IDLE) ? IDX_W'(q_head.idx) : i_r[IDX_W-1:0];
  assign ram_wdata = (state_r == S_IDLE) ? {q_head.x, q_head.y} : {new_x, new_y};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      rd_vld_r <= (state_r == S_SUM) && ram_re;
      if (wr_fire) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end

    case (state_r)
      S_IDLE: begin
        i_r      <= '0;
        n_r      <= n_act;
        sx_r     <= '0;
        sy_r     <= '0;
        scale_r  <= is_scale_op;
        factor_r <= (q_head.op == OP_GROW) ? SCALE_UP_Q16 : SCALE_DOWN_Q16;
        dx_r     <= '0;
        dy_r     <= '0;
        case (q_head.op)
          OP_UP:    dy_r <= STEP_Q8;
          OP_DOWN:  dy_r <= -STEP_Q8;
          OP_LEFT:  dx_r <= -STEP_Q8;
          OP_RIGHT: dx_r <= STEP_Q8;
          default:  ;
        endcase
      end
      S_SUM: begin
        if (ram_re) begin
          i_r <= i_r + CNT_W'(1);
        end
        if (rd_vld_r) begin
          sx_r <= sx_r + SUM_W'(rd_x);
          sy_r <= sy_r + SUM_W'(rd_y);
        end
      end
      S_DIV_WT: begin
        i_r  <= '0;
        cx_r <= qx_div[COORD_W-1:0];
        cy_r <= qy_div[COORD_W-1:0];
      end
      S_UPD_MUL: begin
        vx_r <= rd_x;
        vy_r <= rd_y;
        px_r <= (P_W'(rd_x) - P_W'(cx_r)) * $signed({1'b0, factor_r});
        py_r <= (P_W'(rd_y) - P_W'(cy_r)) * $signed({1'b0, factor_r});
      end
      S_UPD_RND: begin
        negx_r <= px_r[P_W-1];
        negy_r <= py_r[P_W-1];
        qx_r   <= Q_W'((mag_x + P_W'(RND_HALF)) >>> RND_SHIFT);
        qy_r   <= Q_W'((mag_y + P_W'(RND_HALF)) >>> RND_SHIFT);
      end
      S_UPD_WR: begin
        if (wr_fire) begin
          i_r                    <= i_r + CNT_W'(1);
          out_data_r.out_index   <= VIDX_W'(i_r);
          out_data_r.out_x       <= new_x;
          out_data_r.out_y       <= new_y;
          out_data_r.last_vertex <= last;
        end
      end
      default: ;
    endcase
  end

  ptse_ram #(
    .WIDTH (RAM_W),
    .DEPTH (MAX_VERTICES)
  ) u_vtx_ram (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .re      (ram_re),
    .raddr   (ram_raddr),
    .rdata_r (ram_rdata)
  );

  ptse_div #(
    .DIVIDEND_W (SUM_W),
    .DIVISOR_W  (CNT_W)
  ) u_div_x (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (sx_r),
    .divisor  (n_r),
    .busy     (busy_x),
    .quotient (qx_div)
  );

  ptse_div #(
    .DIVIDEND_W (SUM_W),
    .DIVISOR_W  (CNT_W)
  ) u_div_y (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (sy_r),
    .divisor  (n_r),
    .busy     (busy_y),
    .quotient (qy_div)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* hw/rtl/polygon_translate_scale_engine.sv */
// ----------------------------------------------------------------------------
// polygon_translate_scale_engine: polygon vertex table with key-driven moves
// Holds up to MAX_VERTICES vertices in signed Q15.8 and translates or scales
// them about their centroid on key commands, emitting the updated polygon.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall/in_data): a load transaction writes one
//   vertex and gives no result; a key transaction (w/a/s/d, i/o, any case)
//   moves or scales the polygon. Other keys are dropped at the input.
//   Output channel (out_valid/out_stall/out_data): after a recognized key,
//   vertices 0..n-1 come out in order, last_vertex set on the final one.
//   Config channel (cfg_valid/cfg_ready/cfg_data): vertex_count, always ready;
//   write it only while the engine is idle. n is vertex_count clamped to
//   1..MAX_VERTICES.
// Timing:
//   A two-entry command queue sits between decode and the vertex engine, so
//   the input keeps taking transactions while the engine works.
//   Load: a single RAM write from idle. Translate: per vertex a read, a multiply
//   slot, a round slot and a write/emit step. Scale: a centroid pass over the
//   n vertices, a divider start, a bit-serial divide of both sums by n and the
//   collection of the quotients, then per vertex the read, multiply, round and
//   write/emit steps. The single RAM read port and the bit-serial divider set these.
// Reset: synchronous, active low; vertex_count returns to 3, queue and output
//   empty. Vertex contents are undefined until loaded.
// Back-pressure: a stalled result holds in the output register; the engine
//   waits on its write/emit step, and the input stalls once the queue fills.
// ----------------------------------------------------------------------------
module polygon_translate_scale_engine import ptse_pkg::*; #(
  parameter int MAX_VERTICES = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  // input transactions
  input  logic             in_valid,
  output logic             in_stall,
  input  in_item_t         in_data,
  // result transactions
  output logic             out_valid,
  input  logic             out_stall,
  output out_item_t        out_data,
  // vertex_count register write
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CFG_W-1:0] cfg_data
);

  logic [CFG_W-1:0] vcount_r, vcount_nxt;

  logic q_push, q_full, q_pop, q_empty;
  cmd_t q_cmd, q_head;

  // configuration register, no side effects on write
  assign cfg_ready  = 1'b1;
  assign vcount_nxt = (cfg_valid && cfg_ready) ? cfg_data : vcount_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vcount_r <= VCOUNT_RESET;
    end else begin
      vcount_r <= vcount_nxt;
    end
  end

  // front: decode and filter
  ptse_front #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_front (
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_cmd    (q_cmd)
  );

  // queue between decode and engine
  ptse_cmd_q u_cmd_q (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .empty    (q_empty),
    .head     (q_head)
  );

  // back: vertex RAM, centroid, update and result register
  ptse_back #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_empty      (q_empty),
    .q_head       (q_head),
    .q_pop        (q_pop),
    .vertex_count (vcount_r),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_data     (out_data)
  );

endmodule
